[rtl/streamed_conv2d_line_buffer_macros.svh]
// Assertion macros used by the checker file.
`ifndef STREAMED_CONV2D_LINE_BUFFER_MACROS_SVH
`define STREAMED_CONV2D_LINE_BUFFER_MACROS_SVH

// Checks a property on every rising edge of clk, ignored while rst is high.
`define SCLB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a signal holds while a result transfer is stalled.
`define SCLB_HOLD(label, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) \
    (out_valid && out_stall) |=> $stable(sig)) else $error(msg);

`endif

[rtl/sclb_pkg.sv]
package sclb_pkg;

  localparam int CHANNELS  = 1;
  localparam int ROW_WIDTH = 32;
  localparam int ROWS      = 32;
  localparam int FILTERS   = 4;
  localparam int KERNEL    = 3;

  localparam int LINE_DEPTH   = (KERNEL - 1) * ROW_WIDTH * CHANNELS + KERNEL * CHANNELS;
  localparam int WEIGHT_DEPTH = FILTERS * CHANNELS * KERNEL * KERNEL;

  localparam int LP_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int WA_W  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int COL_W = $clog2(ROW_WIDTH);
  localparam int ROW_W = $clog2(ROWS);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int K_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int F_W   = (FILTERS > 1) ? $clog2(FILTERS) : 1;
  localparam int ACC_W = 48;

  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE      = 2'd2;

  typedef struct packed {
    logic            load_weight;
    logic            load_bias;
    logic            sample;
    logic            clear;
    logic            issue;
    logic            finish;
    logic [CH_W-1:0] ch;
    logic [K_W-1:0]  ii;
    logic [K_W-1:0]  jj;
    logic [F_W-1:0]  f;
  } sclb_cmd_t;

  typedef struct packed {
    logic window_hit;
    logic out_busy;
  } sclb_status_t;

endpackage

[rtl/streamed_conv2d_line_buffer.sv]
// A sample that completes a window runs its taps through the registered line and
// weight reads into the single shared multiply-accumulate unit, product register
// first, one filter after another; each result is rounded and registered for output.
// Loads and samples without a window leave the input free; a window sample stalls
// it until its last result is registered. Reset: rst, synchronous and active high,
// clears the state, counters and pointer; line, weight and bias stores are kept.
module streamed_conv2d_line_buffer
  import sclb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic signed [15:0] value,
  input  logic [5:0]         address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] result_value,
  output logic [1:0]         filter_index,
  output logic               last
);

  // The controller sequences the window taps through the shared MAC and
  // hands each rounded result to the output register. The output register
  // lets a new input transfer be taken while the final result still waits.
  sclb_cmd_t    cmd;
  sclb_status_t status;

  sclb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the circular line store, the coefficients, the
  // image position counters and the accumulator with rounding and saturation.
  sclb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .address      (address),
    .result_value (result_value),
    .filter_index (filter_index),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

[rtl/sclb_ram.sv]
module sclb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sclb_ctrl.sv]
module sclb_ctrl
  import sclb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [1:0]   operation,
  output logic         in_stall,
  input  sclb_status_t status,
  output sclb_cmd_t    cmd
);

  typedef enum logic [2:0] {IDLE, MAC, DRAIN, FIN} state_t;

  state_t          state;
  logic [CH_W-1:0] ch;
  logic [K_W-1:0]  ii;
  logic [K_W-1:0]  jj;
  logic [F_W-1:0]  f;
  logic            drain_cnt;
  logic            accept;
  logic            last_tap;

  assign in_stall = (state != IDLE);
  assign accept   = in_valid && !in_stall;
  assign last_tap = (jj == K_W'(KERNEL - 1)) && (ii == K_W'(KERNEL - 1)) &&
                    (ch == CH_W'(CHANNELS - 1));

  always_comb begin
    cmd             = '0;
    cmd.ch          = ch;
    cmd.ii          = ii;
    cmd.jj          = jj;
    cmd.f           = f;
    cmd.load_weight = accept && (operation == OP_LOAD_WEIGHT);
    cmd.load_bias   = accept && (operation == OP_LOAD_BIAS);
    cmd.sample      = accept && (operation == OP_SAMPLE);
    cmd.clear       = cmd.sample || (state == FIN && !status.out_busy);
    cmd.issue       = (state == MAC);
    cmd.finish      = (state == FIN) && !status.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      ch        <= '0;
      ii        <= '0;
      jj        <= '0;
      f         <= '0;
      drain_cnt <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.sample && status.window_hit) begin
            state <= MAC;
            ch    <= '0;
            ii    <= '0;
            jj    <= '0;
            f     <= '0;
          end
        end
        MAC: begin
          if (last_tap) begin
            state     <= DRAIN;
            drain_cnt <= 1'b0;
            ch        <= '0;
            ii        <= '0;
            jj        <= '0;
          end else if (jj != K_W'(KERNEL - 1)) begin
            jj <= jj + K_W'(1);
          end else begin
            jj <= '0;
            if (ii != K_W'(KERNEL - 1)) begin
              ii <= ii + K_W'(1);
            end else begin
              ii <= '0;
              ch <= ch + CH_W'(1);
            end
          end
        end
        DRAIN: begin
          drain_cnt <= 1'b1;
          if (drain_cnt) begin
            state <= FIN;
          end
        end
        FIN: begin
          if (!status.out_busy) begin
            if (f == F_W'(FILTERS - 1)) begin
              state <= IDLE;
            end else begin
              f     <= f + F_W'(1);
              state <= MAC;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[rtl/sclb_datapath.sv]
module sclb_datapath
  import sclb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  sclb_cmd_t          cmd,
  output sclb_status_t       status,
  input  logic signed [15:0] value,
  input  logic [5:0]         address,
  output logic signed [15:0] result_value,
  output logic [1:0]         filter_index,
  output logic               last,
  output logic               out_valid,
  input  logic               out_stall
);

  logic [LP_W-1:0]  wp;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CH_W-1:0]  chc;

  logic signed [15:0] bias [FILTERS];

  logic [LP_W:0]    flat;
  logic [LP_W:0]    pos_sum;
  logic [LP_W-1:0]  pos;
  logic [WA_W-1:0]  wi;
  logic [15:0]      line_q;
  logic [15:0]      weight_q;
  logic             rd_v;
  logic             mul_v;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] total;
  logic signed [ACC_W-1:0] rounded;
  logic signed [15:0]      sat;

  assign status.window_hit = (chc == CH_W'(CHANNELS - 1)) &&
                             (col >= COL_W'(KERNEL - 1)) && (row >= ROW_W'(KERNEL - 1));
  assign status.out_busy   = out_valid && out_stall;

  // Window tap address: offset from the oldest stored sample.
  assign flat = (LP_W+1)'(cmd.ii) * (LP_W+1)'(ROW_WIDTH * CHANNELS) +
                (LP_W+1)'(cmd.jj) * (LP_W+1)'(CHANNELS) + (LP_W+1)'(cmd.ch);
  assign pos_sum = (LP_W+1)'(wp) + flat;
  assign pos = (pos_sum >= (LP_W+1)'(LINE_DEPTH)) ?
               LP_W'(pos_sum - (LP_W+1)'(LINE_DEPTH)) : LP_W'(pos_sum);
  assign wi = WA_W'((WA_W+F_W)'(cmd.f) * (WA_W+F_W)'(CHANNELS * KERNEL * KERNEL) +
                    (WA_W+F_W)'(cmd.ch) * (WA_W+F_W)'(KERNEL * KERNEL) +
                    (WA_W+F_W)'(cmd.ii) * (WA_W+F_W)'(KERNEL) + (WA_W+F_W)'(cmd.jj));

  sclb_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (cmd.sample),
    .waddr (wp),
    .wdata (value),
    .raddr (pos),
    .rdata (line_q)
  );

  sclb_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight (
    .clk   (clk),
    .we    (cmd.load_weight && (address < 6'(WEIGHT_DEPTH))),
    .waddr (address[WA_W-1:0]),
    .wdata (value),
    .raddr (wi),
    .rdata (weight_q)
  );

  assign total   = acc + (ACC_W'(bias[cmd.f]) <<< 12);
  assign rounded = (total + ACC_W'(2048)) >>> 12;
  always_comb begin
    if (rounded > ACC_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (rounded < -ACC_W'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = rounded[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bias && (address < 6'(FILTERS))) begin
      bias[address[F_W-1:0]] <= value;
    end
    prod <= $signed(line_q) * $signed(weight_q);
    if (cmd.clear) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.finish) begin
      result_value <= sat;
      filter_index <= 2'(cmd.f);
      last         <= (cmd.f == F_W'(FILTERS - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      col       <= '0;
      row       <= '0;
      chc       <= '0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.sample) begin
        wp <= (wp == LP_W'(LINE_DEPTH - 1)) ? '0 : wp + LP_W'(1);
        if (chc == CH_W'(CHANNELS - 1)) begin
          chc <= '0;
          if (col == COL_W'(ROW_WIDTH - 1)) begin
            col <= '0;
            row <= (row == ROW_W'(ROWS - 1)) ? '0 : row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end else begin
          chc <= chc + CH_W'(1);
        end
      end
    end
  end

endmodule

[rtl/sclb_checker.sv]
`include "streamed_conv2d_line_buffer_macros.svh"

module sclb_checker
  import sclb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] result_value,
  input logic [1:0]  filter_index,
  input logic        last
);

  `SCLB_ASSERT(a_last_on_final, (out_valid && last) |-> (filter_index == 2'(FILTERS - 1)), "last on wrong filter")
  `SCLB_ASSERT(a_busy_mid_window, (out_valid && !last) |-> in_stall, "input taken mid window")
  `SCLB_HOLD(a_hold_value, result_value, "result changed while stalled")

endmodule

bind streamed_conv2d_line_buffer sclb_checker u_sclb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .filter_index (filter_index),
  .last         (last)
);
